// ===== design/tralu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Thumb register ALU pipeline.
// No dependencies; imported by every module of the block.
package tralu_pkg;

    localparam int DATA_W      = 32;
    localparam int AMT_W       = 8;
    localparam int SHIFT_W     = 5;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;

    localparam logic [DATA_W-1:0] SIGN_MASK = 32'h8000_0000;
    localparam logic [AMT_W-1:0]  BYTE_MASK = 8'hFF;
    localparam logic [AMT_W-1:0]  AMT_WORD  = 8'd32;

    // Thumb format 4 operation codes
    typedef enum logic [3:0] {
        OP_AND, OP_EOR, OP_LSL, OP_LSR, OP_ASR, OP_ADC, OP_SBC, OP_ROR,
        OP_TST, OP_NEG, OP_CMP, OP_CMN, OP_ORR, OP_MUL, OP_BIC, OP_MVN
    } op_t;

    // Input item as received on the slave side
    typedef struct packed {
        op_t               req_type;
        logic [DATA_W-1:0] dest_value;
        logic [DATA_W-1:0] source_value;
        logic              carry_in;
        logic              overflow_in;
    } in_item_t;

    // Stage 1 -> stage 2: operands, adder inputs, product, shift decode
    typedef struct packed {
        op_t                op;
        logic [DATA_W-1:0]  a;
        logic [DATA_W-1:0]  b;
        logic               c;
        logic               v;
        logic [DATA_W-1:0]  add_x;
        logic [DATA_W-1:0]  add_y;
        logic               add_cin;
        logic [DATA_W-1:0]  product;
        logic               amt_zero;
        logic               amt_lt32;
        logic               amt_eq32;
        logic [SHIFT_W-1:0] shamt;
    } dec_t;

    // Stage 2 -> stage 3: selected result and C/V
    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              write_back;
        logic              carry;
        logic              overflow;
    } exe_t;

    // Result item as sent on the master side
    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic              write_back;
        logic              flag_negative;
        logic              flag_zero;
        logic              flag_carry;
        logic              flag_overflow;
    } out_item_t;

endpackage

// ===== design/tralu_decode.sv =====
`timescale 1ns / 1ps
// Stage 1: operand capture, adder operand muxing, multiply, shift amount decode.
// Depends on tralu_pkg.
module tralu_decode
    import tralu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    input  in_item_t in_item,
    output logic     in_ready,
    output logic     out_valid,
    output dec_t     out_item,
    input  logic     out_ready
);

    logic             valid_reg;
    logic             valid_next;
    dec_t             data_reg;
    dec_t             data_next;
    logic [AMT_W-1:0] amt;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = data_reg;
    assign amt       = in_item.source_value[AMT_W-1:0] & BYTE_MASK;

    // Operand preparation; subtracts become x + ~y + cin
    always_comb begin
        data_next          = '0;
        data_next.op       = in_item.req_type;
        data_next.a        = in_item.dest_value;
        data_next.b        = in_item.source_value;
        data_next.c        = in_item.carry_in;
        data_next.v        = in_item.overflow_in;
        data_next.product  = in_item.dest_value * in_item.source_value;
        data_next.amt_zero = (amt == '0);
        data_next.amt_lt32 = (amt < AMT_WORD);
        data_next.amt_eq32 = (amt == AMT_WORD);
        data_next.shamt    = amt[SHIFT_W-1:0];
        case (in_item.req_type)
            OP_ADC: begin
                data_next.add_x   = in_item.dest_value;
                data_next.add_y   = in_item.source_value;
                data_next.add_cin = in_item.carry_in;
            end
            OP_SBC: begin
                data_next.add_x   = in_item.dest_value;
                data_next.add_y   = ~in_item.source_value;
                data_next.add_cin = in_item.carry_in;
            end
            OP_NEG: begin
                data_next.add_x   = '0;
                data_next.add_y   = ~in_item.source_value;
                data_next.add_cin = 1'b1;
            end
            OP_CMP: begin
                data_next.add_x   = in_item.dest_value;
                data_next.add_y   = ~in_item.source_value;
                data_next.add_cin = 1'b1;
            end
            default: begin
                data_next.add_x   = in_item.dest_value;
                data_next.add_y   = in_item.source_value;
                data_next.add_cin = 1'b0;
            end
        endcase
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    // Stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== design/tralu_execute.sv =====
`timescale 1ns / 1ps
// Stage 2: adder, barrel shifter, logic unit and result select.
// Depends on tralu_pkg.
module tralu_execute
    import tralu_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    input  dec_t in_item,
    output logic in_ready,
    output logic out_valid,
    output exe_t out_item,
    input  logic out_ready
);

    logic                valid_reg;
    logic                valid_next;
    exe_t                data_reg;
    exe_t                data_next;
    logic [DATA_W:0]     sum;
    logic [DATA_W-1:0]   a;
    logic [SHIFT_W-1:0]  n;
    logic [SHIFT_W-1:0]  idx_dn;
    logic [SHIFT_W-1:0]  idx_up;
    logic [2*DATA_W-1:0] rot;
    logic                add_v;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = data_reg;

    assign a      = in_item.a;
    assign n      = in_item.shamt;
    assign idx_dn = n - SHIFT_W'(1);
    assign idx_up = SHIFT_W'(7'(DATA_W) - 7'(n));
    assign rot    = {a, a} >> n;

    // Shared adder and its overflow
    assign sum   = {1'b0, in_item.add_x} + {1'b0, in_item.add_y}
                 + (DATA_W+1)'(in_item.add_cin);
    assign add_v = |(~(in_item.add_x ^ in_item.add_y)
                   & (in_item.add_x ^ sum[DATA_W-1:0]) & SIGN_MASK);

    // Result and C/V select
    always_comb begin
        data_next            = '0;
        data_next.write_back = 1'b1;
        data_next.carry      = in_item.c;
        data_next.overflow   = in_item.v;
        case (in_item.op)
            OP_AND: data_next.result = a & in_item.b;
            OP_EOR: data_next.result = a ^ in_item.b;
            OP_ORR: data_next.result = a | in_item.b;
            OP_BIC: data_next.result = a & ~in_item.b;
            OP_MVN: data_next.result = ~in_item.b;
            OP_MUL: data_next.result = in_item.product;
            OP_TST: begin
                data_next.result     = a & in_item.b;
                data_next.write_back = 1'b0;
            end
            OP_LSL: begin
                if (in_item.amt_zero) begin
                    data_next.result = a;
                end else if (in_item.amt_lt32) begin
                    data_next.result = a << n;
                    data_next.carry  = a[idx_up];
                end else if (in_item.amt_eq32) begin
                    data_next.carry  = a[0];
                end else begin
                    data_next.carry  = 1'b0;
                end
            end
            OP_LSR: begin
                if (in_item.amt_zero) begin
                    data_next.result = a;
                end else if (in_item.amt_lt32) begin
                    data_next.result = a >> n;
                    data_next.carry  = a[idx_dn];
                end else if (in_item.amt_eq32) begin
                    data_next.carry  = a[DATA_W-1];
                end else begin
                    data_next.carry  = 1'b0;
                end
            end
            OP_ASR: begin
                if (in_item.amt_zero) begin
                    data_next.result = a;
                end else if (in_item.amt_lt32) begin
                    data_next.result = DATA_W'($signed(a) >>> n);
                    data_next.carry  = a[idx_dn];
                end else begin
                    data_next.result = {DATA_W{a[DATA_W-1]}};
                    data_next.carry  = a[DATA_W-1];
                end
            end
            OP_ROR: begin
                if (in_item.amt_zero) begin
                    data_next.result = a;
                end else if (n == '0) begin
                    data_next.result = a;
                    data_next.carry  = a[DATA_W-1];
                end else begin
                    data_next.result = rot[DATA_W-1:0];
                    data_next.carry  = a[idx_dn];
                end
            end
            OP_ADC, OP_SBC, OP_NEG: begin
                data_next.result   = sum[DATA_W-1:0];
                data_next.carry    = sum[DATA_W];
                data_next.overflow = add_v;
            end
            OP_CMP, OP_CMN: begin
                data_next.result     = sum[DATA_W-1:0];
                data_next.carry      = sum[DATA_W];
                data_next.overflow   = add_v;
                data_next.write_back = 1'b0;
            end
            default: data_next.result = a;
        endcase
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    // Stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== design/tralu_output.sv =====
`timescale 1ns / 1ps
// Stage 3: N/Z flag generation and the output register of the master side.
// Depends on tralu_pkg.
module tralu_output
    import tralu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  exe_t      in_item,
    output logic      in_ready,
    output logic      out_valid,
    output out_item_t out_item,
    input  logic      out_ready
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;
    out_item_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = data_reg;

    // Flags from the final result
    always_comb begin
        data_next.result_value  = in_item.result;
        data_next.write_back    = in_item.write_back;
        data_next.flag_negative = in_item.result[DATA_W-1];
        data_next.flag_zero     = (in_item.result == '0);
        data_next.flag_carry    = in_item.carry;
        data_next.flag_overflow = in_item.overflow;
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    // Output register; holds while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== design/thumb_register_alu_with_flags.sv =====
`timescale 1ns / 1ps
// Thumb format 4 register ALU: AND, EOR, shifts, ADC, SBC, ROR, TST, NEG,
// CMP, CMN, ORR, MUL, BIC, MVN with N/Z/C/V flags. Uses tralu_pkg and stages.
//
// Usage:
//  - Slave channel (s_t*) carries one operation per transfer: opcode, Rd and
//    Rs values and the current C and V flags.
//  - Master channel (m_t*) returns one result per operation, in order: the
//    32-bit value, the write-back enable and the new N, Z, C, V flags.
//  - Items pass the stages in order: stage 1 muxes the adder operands and
//    forms the product, stage 2 runs the adder, shifter and logic unit,
//    stage 3 derives N/Z and drives the output register feeding m_tvalid.
//  - Throughput is one operation per cycle without stalls; each stage takes
//    a new item when it is empty or its contents move on in the same cycle.
//  - When m_tready is low the output register holds; the stages behind it
//    keep filling, and s_tready drops only when all three are occupied.
//  - Reset (aresetn low at a clock edge) empties all stages; no results are
//    pending afterwards.
module thumb_register_alu_with_flags
    import tralu_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [3:0] req_type, [35:4] dest_value, [67:36] source_value,
    // [68] carry_in, [69] overflow_in, [71:70] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [31:0] result_value, [32] write_back, [33] flag_negative,
    // [34] flag_zero, [35] flag_carry, [36] flag_overflow, [39:37] zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    in_item_t  in_item;
    dec_t      dec_item;
    exe_t      exe_item;
    out_item_t out_item;
    logic      dec_valid;
    logic      exe_valid;
    logic      exe_ready;
    logic      out_ready;

    // Unpack the slave transfer
    assign in_item.req_type     = op_t'(s_tdata[3:0]);
    assign in_item.dest_value   = s_tdata[35:4];
    assign in_item.source_value = s_tdata[67:36];
    assign in_item.carry_in     = s_tdata[68];
    assign in_item.overflow_in  = s_tdata[69];

    tralu_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_item   (in_item),
        .in_ready  (s_tready),
        .out_valid (dec_valid),
        .out_item  (dec_item),
        .out_ready (exe_ready)
    );

    tralu_execute u_execute (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_item   (dec_item),
        .in_ready  (exe_ready),
        .out_valid (exe_valid),
        .out_item  (exe_item),
        .out_ready (out_ready)
    );

    tralu_output u_output (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (exe_valid),
        .in_item   (exe_item),
        .in_ready  (out_ready),
        .out_valid (m_tvalid),
        .out_item  (out_item),
        .out_ready (m_tready)
    );

    // Pack the master transfer
    assign m_tdata = {3'b000,
                      out_item.flag_overflow,
                      out_item.flag_carry,
                      out_item.flag_zero,
                      out_item.flag_negative,
                      out_item.write_back,
                      out_item.result_value};

endmodule

// ===== design/tralu_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for thumb_register_alu_with_flags, bound to the top level.
// Depends on tralu_pkg.
module tralu_checker
    import tralu_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // Stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // N flag follows bit 31 of the result
    a_neg_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[33] == m_tdata[31])
        else $error("N flag does not match result sign");

    // Z flag matches a zero result
    a_zero_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[34] == (m_tdata[31:0] == '0))
        else $error("Z flag does not match result");

    // Without stalls or reset, an accepted item passes all stage registers to m_tvalid
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(s_tvalid && s_tready && aresetn, 3) && $past(aresetn, 2)
        && $past(aresetn, 1) && $past(m_tready, 2) && $past(m_tready, 1)
        |-> m_tvalid)
        else $error("result missing after pipeline latency");

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind thumb_register_alu_with_flags tralu_checker u_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for thumb_register_alu_with_flags: a directed table, then random
// operations, checked against an in-bench ALU predictor. Depends on tralu_pkg and the RTL.
module testbench
    import tralu_pkg::*;
();

    // One operation as sent on the slave side
    typedef struct {
        op_t         op;
        logic [31:0] rd;
        logic [31:0] rs;
        logic        c;
        logic        v;
    } alu_req_t;

    // One result as returned on the master side
    typedef struct {
        logic [31:0] value;
        logic        wb;
        logic        n;
        logic        z;
        logic        c;
        logic        v;
    } alu_res_t;

    // Directed row: expected result is only used when hand_checked is set
    typedef struct {
        alu_req_t req;
        bit       hand_checked;
        alu_res_t want;
    } dir_row_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // [3:0] req_type, [35:4] dest_value, [67:36] source_value,
    // [68] carry_in, [69] overflow_in, [71:70] zero
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [31:0] result_value, [32] write_back, [33] flag_negative,
    // [34] flag_zero, [35] flag_carry, [36] flag_overflow, [39:37] zero
    logic [OUT_TDATA_W-1:0] m_tdata;

    alu_res_t alu_expected[$];
    dir_row_t dir_rows[$];
    int       err_count    = 0;
    int       ops_sent     = 0;
    int       results_seen = 0;
    int       burst_left   = 0;
    int       stall_left   = 0;
    int       stall_phase  = 0;
    logic [15:0] stall_mask = 16'hFFFF;

    thumb_register_alu_with_flags u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // ALU predictor: result, write-back and new NZCV for one operation
    function automatic alu_res_t alu_eval(input alu_req_t q);
        alu_res_t    res;
        logic [31:0] a, b, r;
        logic [7:0]  amt;
        logic [4:0]  rot;
        logic [32:0] wide, sub_rhs;
        logic        c, v, wb;
        a   = q.rd;
        b   = q.rs;
        c   = q.c;
        v   = q.v;
        wb  = 1'b1;
        amt = b[7:0];
        r   = '0;
        case (q.op)
            OP_AND: r = a & b;
            OP_EOR: r = a ^ b;
            OP_LSL: begin
                if (amt == 0) begin
                    r = a;
                end else if (amt < 32) begin
                    c = a[32 - amt];
                    r = a << amt;
                end else begin
                    c = (amt == AMT_WORD) ? a[0] : 1'b0;
                    r = '0;
                end
            end
            OP_LSR: begin
                if (amt == 0) begin
                    r = a;
                end else if (amt < 32) begin
                    c = a[amt - 1];
                    r = a >> amt;
                end else begin
                    c = (amt == AMT_WORD) ? a[31] : 1'b0;
                    r = '0;
                end
            end
            OP_ASR: begin
                if (amt == 0) begin
                    r = a;
                end else if (amt < 32) begin
                    c = a[amt - 1];
                    r = $unsigned($signed(a) >>> amt);
                end else begin
                    c = a[31];
                    r = {32{a[31]}};
                end
            end
            OP_ADC, OP_CMN: begin
                wide = {1'b0, a} + {1'b0, b} + ((q.op == OP_ADC) ? {32'd0, c} : 33'd0);
                r    = wide[31:0];
                c    = wide[32];
                v    = ~(a[31] ^ b[31]) & (a[31] ^ r[31]);
                wb   = (q.op == OP_ADC);
            end
            OP_SBC: begin
                sub_rhs = {1'b0, b} + {32'd0, ~c};
                r       = a - b - {31'd0, ~c};
                c       = ({1'b0, a} >= sub_rhs);
                v       = (a[31] ^ b[31]) & (a[31] ^ r[31]);
            end
            OP_ROR: begin
                rot = amt[4:0];
                if (amt == 0) begin
                    r = a;
                end else if (rot == 0) begin
                    r = a;
                    c = a[31];
                end else begin
                    r = (a >> rot) | (a << (32 - rot));
                    c = a[rot - 1];
                end
            end
            OP_TST: begin
                r  = a & b;
                wb = 1'b0;
            end
            OP_NEG: begin
                r = 32'd0 - b;
                c = (b == 0);
                v = b[31] & r[31];
            end
            OP_CMP: begin
                r  = a - b;
                c  = (a >= b);
                v  = (a[31] ^ b[31]) & (a[31] ^ r[31]);
                wb = 1'b0;
            end
            OP_ORR: r = a | b;
            OP_MUL: r = a * b;
            OP_BIC: r = a & ~b;
            default: r = ~b;
        endcase
        res.value = r;
        res.wb    = wb;
        res.n     = r[31];
        res.z     = (r == 0);
        res.c     = c;
        res.v     = v;
        return res;
    endfunction

    task automatic add_row(input op_t op, input logic [31:0] rd, input logic [31:0] rs,
                           input logic c, input logic v, input bit hand_checked,
                           input logic [31:0] value, input logic wb, input logic [3:0] nzcv);
        dir_row_t row;
        row.req          = '{op: op, rd: rd, rs: rs, c: c, v: v};
        row.hand_checked = hand_checked;
        row.want         = '{value: value, wb: wb, n: nzcv[3], z: nzcv[2],
                             c: nzcv[1], v: nzcv[0]};
        dir_rows.push_back(row);
    endtask

    task automatic flag_error(input string what, input alu_res_t want, input alu_res_t got);
        err_count++;
        if (err_count <= 10) begin
            $display("ERROR @%0t: %s", $realtime, what);
            $display("  expected value=%08h wb=%b nzcv=%b%b%b%b",
                     want.value, want.wb, want.n, want.z, want.c, want.v);
            $display("  actual   value=%08h wb=%b nzcv=%b%b%b%b",
                     got.value, got.wb, got.n, got.z, got.c, got.v);
        end
    endtask

    // Send one operation, queue its expected result at the transfer, then maybe pause
    task automatic send_op(input alu_req_t q, input alu_res_t want);
        s_tdata  <= {2'b00, q.v, q.c, q.rs, q.rd, q.op};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        alu_expected.push_back(want);
        ops_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Operand with a bias toward the corners of the 32-bit range
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return SIGN_MASK;
            3: return ~SIGN_MASK;
            4: return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    // Shift amount in the low byte, junk or zeros above it
    function automatic logic [31:0] pick_shift();
        logic [7:0] amt;
        case ($urandom_range(0, 5))
            0: amt = 8'd0;
            1: amt = AMT_WORD;
            2: amt = 8'($urandom_range(33, 255));
            3: amt = {3'($urandom_range(1, 7)), 5'd0};
            default: amt = 8'($urandom_range(1, 31));
        endcase
        return {($urandom_range(0, 1) != 0) ? 24'h0 : 24'($urandom()), amt};
    endfunction

    // Receiver: checks each result transfer, then applies its own stall pattern
    always @(posedge aclk) begin
        alu_res_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.value = m_tdata[31:0];
                got.wb    = m_tdata[32];
                got.n     = m_tdata[33];
                got.z     = m_tdata[34];
                got.c     = m_tdata[35];
                got.v     = m_tdata[36];
                results_seen++;
                if (alu_expected.size() == 0) begin
                    want = got;
                    flag_error("result with no operation outstanding", want, got);
                end else begin
                    want = alu_expected.pop_front();
                    if (got.value !== want.value || got.wb !== want.wb ||
                        got.n !== want.n || got.z !== want.z ||
                        got.c !== want.c || got.v !== want.v)
                        flag_error("result mismatch", want, got);
                end
            end
            if (stall_left == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_mask = 16'hFFFF;
                    1: stall_mask = 16'($urandom());
                    2: stall_mask = 16'h1111;
                    default: stall_mask = 16'($urandom() | $urandom());
                endcase
                stall_left = $urandom_range(30, 150);
            end else begin
                stall_left--;
            end
            stall_phase = (stall_phase + 1) % 16;
            m_tready <= stall_mask[stall_phase];
        end
    end

    // Hard stop if the pipeline hangs
    initial begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    initial begin
        alu_req_t q;
        alu_res_t want;
        int       n_dir;
        // Directed table: corners of each operation and the special shift amounts
        add_row(OP_AND, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1, 1, 32'h0000_0000, 1, 4'b0111);
        add_row(OP_EOR, 32'hFFFF_FFFF, 32'h0000_0000, 0, 0, 1, 32'hFFFF_FFFF, 1, 4'b1000);
        // only the low byte counts: 0x100 is a zero shift, C kept
        add_row(OP_LSL, 32'h0000_0001, 32'h0000_0100, 1, 0, 1, 32'h0000_0001, 1, 4'b0010);
        add_row(OP_LSL, 32'h8000_0001, 32'h0000_0001, 0, 0, 0, '0, 0, 4'b0000);
        add_row(OP_LSL, 32'h0000_0001, 32'h0000_0020, 0, 0, 1, 32'h0000_0000, 1, 4'b0110);
        add_row(OP_LSL, 32'hFFFF_FFFF, 32'h0000_0021, 1, 1, 1, 32'h0000_0000, 1, 4'b0101);
        add_row(OP_LSR, 32'h8000_0000, 32'h0000_0020, 0, 0, 1, 32'h0000_0000, 1, 4'b0110);
        add_row(OP_LSR, 32'hFFFF_FFFF, 32'h0000_00FF, 1, 0, 1, 32'h0000_0000, 1, 4'b0100);
        add_row(OP_ASR, 32'h8000_0000, 32'h0000_0020, 0, 1, 1, 32'hFFFF_FFFF, 1, 4'b1011);
        add_row(OP_ASR, 32'h8000_0000, 32'h0000_001F, 0, 0, 0, '0, 0, 4'b0000);
        add_row(OP_ASR, 32'h7FFF_FFFF, 32'h0000_00C8, 1, 0, 1, 32'h0000_0000, 1, 4'b0100);
        add_row(OP_ADC, 32'hFFFF_FFFF, 32'h0000_0000, 1, 0, 1, 32'h0000_0000, 1, 4'b0110);
        add_row(OP_ADC, 32'h7FFF_FFFF, 32'h0000_0000, 1, 0, 1, 32'h8000_0000, 1, 4'b1001);
        add_row(OP_SBC, 32'h0000_0000, 32'h0000_0000, 0, 1, 1, 32'hFFFF_FFFF, 1, 4'b1000);
        add_row(OP_SBC, 32'h8000_0000, 32'h0000_0001, 1, 0, 1, 32'h7FFF_FFFF, 1, 4'b0011);
        // rotate by a nonzero multiple of 32: value kept, C from bit 31
        add_row(OP_ROR, 32'h8000_0001, 32'h0000_0040, 0, 0, 1, 32'h8000_0001, 1, 4'b1010);
        add_row(OP_TST, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 1, 0, 1, 32'h0000_0000, 0, 4'b0110);
        add_row(OP_NEG, 32'hFFFF_FFFF, 32'h0000_0000, 0, 1, 1, 32'h0000_0000, 1, 4'b0110);
        add_row(OP_NEG, 32'h0000_0000, 32'h8000_0000, 1, 0, 1, 32'h8000_0000, 1, 4'b1001);
        add_row(OP_CMP, 32'h0000_0005, 32'h0000_0005, 0, 1, 1, 32'h0000_0000, 0, 4'b0110);
        add_row(OP_CMN, 32'hFFFF_FFFF, 32'h0000_0001, 0, 1, 1, 32'h0000_0000, 0, 4'b0110);
        add_row(OP_ORR, 32'h1234_5678, 32'h8000_0000, 0, 1, 0, '0, 0, 4'b0000);
        add_row(OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, 32'h0000_0001, 1, 4'b0011);
        add_row(OP_BIC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, '0, 0, 4'b0000);
        add_row(OP_MVN, 32'h1234_5678, 32'h0000_0000, 0, 0, 1, 32'hFFFF_FFFF, 1, 4'b1000);
        n_dir = dir_rows.size();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            want = dir_rows[i].hand_checked ? dir_rows[i].want : alu_eval(dir_rows[i].req);
            send_op(dir_rows[i].req, want);
        end

        // Random operations, corner-weighted operands
        repeat (1350) begin
            q.op = op_t'($urandom_range(0, 15));
            q.rd = pick_word();
            if (q.op inside {OP_LSL, OP_LSR, OP_ASR, OP_ROR})
                q.rs = pick_shift();
            else if ($urandom_range(0, 7) == 0)
                q.rs = q.rd;
            else
                q.rs = pick_word();
            q.c = 1'($urandom_range(0, 1));
            q.v = 1'($urandom_range(0, 1));
            send_op(q, alu_eval(q));
        end
        s_tvalid <= 1'b0;

        // Drain, then keep the clock running to catch stray results
        while (alu_expected.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("summary: %0d operations (%0d from the directed table), %0d results checked,",
                 ops_sent, n_dir, results_seen);
        $display("summary: all sixteen opcodes, shift corners, random stalls on both sides");
        if (err_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("summary: %0d mismatching or unexpected results", err_count);
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/tralu_pkg.sv
design/tralu_decode.sv
design/tralu_execute.sv
design/tralu_output.sv
design/thumb_register_alu_with_flags.sv
design/tralu_checker.sv
dv/testbench.sv
